// ----- hw/rtl/multiplexed_decimal_seven_segment_scan_defines.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef MULTIPLEXED_DECIMAL_SEVEN_SEGMENT_SCAN_DEFINES_SVH
`define MULTIPLEXED_DECIMAL_SEVEN_SEGMENT_SCAN_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define MDSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define MDSS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MDSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MDSS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/mdss_pkg.sv -----
package mdss_pkg;

  localparam int unsigned ReadingW = 10;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned EnableW  = 4;
  localparam int unsigned SegW     = 7;
  localparam int unsigned IdxW     = 2;
  localparam int unsigned QDepth   = 2;

  // Reciprocal of ten, scaled by 2^11; exact for values below 1029
  localparam int unsigned RecipTen   = 205;
  localparam int unsigned RecipShift = 11;

  // Digit positions, units first
  localparam logic [IdxW-1:0] IdxUnits = 2'd0;
  localparam logic [IdxW-1:0] IdxTens  = 2'd1;
  localparam logic [IdxW-1:0] IdxHund  = 2'd2;
  localparam logic [IdxW-1:0] IdxThou  = 2'd3;

  localparam logic [DigitW-1:0] DigitTen = 4'd10;

  // One classified reading: its digits and the index of its last shown digit
  typedef struct packed {
    logic [DigitW-1:0] units;
    logic [DigitW-1:0] tens;
    logic [DigitW-1:0] hund;
    logic [IdxW-1:0]   last_idx;
  } digit_entry_t;

  // Active-low gfedcba pattern for a decimal digit; blank for anything else
  function automatic logic [SegW-1:0] seg_pattern(input logic [DigitW-1:0] d);
    logic [SegW-1:0] glyph;
    begin
      unique case (d)
        4'd0: glyph = 7'h3F;
        4'd1: glyph = 7'h06;
        4'd2: glyph = 7'h5B;
        4'd3: glyph = 7'h4F;
        4'd4: glyph = 7'h66;
        4'd5: glyph = 7'h6D;
        4'd6: glyph = 7'h7D;
        4'd7: glyph = 7'h07;
        4'd8: glyph = 7'h7F;
        4'd9: glyph = 7'h6F;
        default: glyph = 7'h00;
      endcase
      seg_pattern = ~glyph;
    end
  endfunction

endpackage

// ----- hw/rtl/multiplexed_decimal_seven_segment_scan.sv -----
// Decimal scan for a multiplexed seven-segment display. Each reading (0..1023)
// turns into one transfer per shown digit, units first: one digit for 0..9,
// two for 10..99, three for 100..999 and four for 1000..1023. Each transfer
// carries a one-hot digit enable, an active-low gfedcba pattern (bit0 is a,
// 0 is lit) and a flag on the final digit of that reading. A reading passes
// the front register, the queue and the back-end entry register on its way
// to the output register; the back-end sequencer drives one digit per cycle
// into it while out_ready does not stall it, and a two-entry queue lets the
// front divide the next readings by ten meanwhile, so back-to-back readings
// stream out with no gap. Nothing needs clearing after reset.
`include "multiplexed_decimal_seven_segment_scan_defines.svh"

module multiplexed_decimal_seven_segment_scan (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mdss_pkg::ReadingW-1:0]    in_reading,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mdss_pkg::EnableW-1:0]     out_digit_enable,
  output logic [mdss_pkg::SegW-1:0]        out_segments_n,
  output logic                             out_last_digit
);

  logic                   push_valid;
  logic                   push_ready;
  mdss_pkg::digit_entry_t push_data;
  logic                   pop_valid;
  logic                   pop_ready;
  mdss_pkg::digit_entry_t pop_data;

  mdss_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_reading (in_reading),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  mdss_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mdss_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_data         (pop_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_digit_enable (out_digit_enable),
    .out_segments_n   (out_segments_n),
    .out_last_digit   (out_last_digit)
  );

  // Check the digit sequencing
  `MDSS_ASSERT_IMP(a_enable_onehot, clk, rst_n, out_valid, $onehot(out_digit_enable), "enable not one-hot")
  `MDSS_ASSERT_IMP(a_thou_is_last, clk, rst_n, out_valid && out_digit_enable[3], out_last_digit, "thousands digit not last")
  `MDSS_ASSERT_IMP(a_thou_glyph, clk, rst_n, out_valid && out_digit_enable[3], out_segments_n == 7'h79, "thousands glyph wrong")
  `MDSS_ASSERT_NXT(a_next_after_last, clk, rst_n, out_valid && out_ready && out_last_digit && !u_back.busy_r, !out_valid || out_digit_enable[0], "reading does not start at units")

endmodule

// ----- hw/rtl/mdss_front.sv -----
module mdss_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [mdss_pkg::ReadingW-1:0]        in_reading,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output mdss_pkg::digit_entry_t               push_data
);

  logic                          s1_valid_r;
  logic [mdss_pkg::ReadingW-1:0] v_r;
  logic [6:0]                    q1_r;
  logic [17:0]                   q1_prod;
  logic [10:0]                   q1_times10;
  logic [14:0]                   q2_prod;
  logic [3:0]                    q2;
  logic [6:0]                    q2_times10;
  logic [9:0]                    units_full;
  logic [6:0]                    tens_full;

  assign in_ready = !s1_valid_r || push_ready;

  // First divide by ten through the scaled reciprocal
  assign q1_prod = 18'(in_reading) * 18'(mdss_pkg::RecipTen);

  // Hold the reading and its quotient until the queue takes the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      v_r  <= in_reading;
      q1_r <= q1_prod[17:mdss_pkg::RecipShift];
    end
  end

  // Split remainders and second quotient, then classify the digit count
  always_comb begin
    q1_times10 = {1'b0, q1_r, 3'b000} + {3'b000, q1_r, 1'b0};
    units_full = v_r - q1_times10[9:0];
    q2_prod    = 15'(q1_r) * 15'(mdss_pkg::RecipTen);
    q2         = q2_prod[14:mdss_pkg::RecipShift];
    q2_times10 = {q2[3:0], 3'b000} + {2'b00, q2, 1'b0};
    tens_full  = q1_r - q2_times10;

    push_data.units = units_full[3:0];
    push_data.tens  = tens_full[3:0];
    push_data.hund  = (q2 == mdss_pkg::DigitTen) ? '0 : q2;
    priority if (v_r > 10'd999) begin
      push_data.last_idx = mdss_pkg::IdxThou;
    end else if (v_r > 10'd99) begin
      push_data.last_idx = mdss_pkg::IdxHund;
    end else if (v_r > 10'd9) begin
      push_data.last_idx = mdss_pkg::IdxTens;
    end else begin
      push_data.last_idx = mdss_pkg::IdxUnits;
    end
  end

  assign push_valid = s1_valid_r;

endmodule

// ----- hw/rtl/mdss_queue.sv -----
module mdss_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  mdss_pkg::digit_entry_t push_data,
  output logic                   pop_valid,
  input  logic                   pop_ready,
  output mdss_pkg::digit_entry_t pop_data
);

  mdss_pkg::digit_entry_t mem_r [mdss_pkg::QDepth];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'(mdss_pkg::QDepth));
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and track fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- hw/rtl/mdss_back.sv -----
module mdss_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             pop_valid,
  output logic                             pop_ready,
  input  mdss_pkg::digit_entry_t           pop_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mdss_pkg::EnableW-1:0]     out_digit_enable,
  output logic [mdss_pkg::SegW-1:0]        out_segments_n,
  output logic                             out_last_digit
);

  logic                          busy_r;
  mdss_pkg::digit_entry_t        ent_r;
  logic [mdss_pkg::IdxW-1:0]     idx_r;
  logic                          out_valid_r;
  logic [mdss_pkg::EnableW-1:0]  enable_r;
  logic [mdss_pkg::SegW-1:0]     seg_r;
  logic                          last_r;
  logic                          slot_free;
  logic                          emit;
  logic                          at_last;
  logic [mdss_pkg::DigitW-1:0]   cur_digit;

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = busy_r && slot_free;
  assign at_last   = (idx_r == ent_r.last_idx);
  assign pop_ready = !busy_r || (emit && at_last);

  // Pick the digit for the current position; thousands is always one
  always_comb begin
    unique case (idx_r)
      mdss_pkg::IdxUnits: cur_digit = ent_r.units;
      mdss_pkg::IdxTens:  cur_digit = ent_r.tens;
      mdss_pkg::IdxHund:  cur_digit = ent_r.hund;
      default:            cur_digit = 4'd1;
    endcase
  end

  // Step through the digits of the held entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (pop_valid && pop_ready) begin
      busy_r <= 1'b1;
      idx_r  <= mdss_pkg::IdxUnits;
    end else if (emit && at_last) begin
      busy_r <= 1'b0;
    end else if (emit) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      ent_r <= pop_data;
    end
  end

  // Output register: load a digit when the slot is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (emit) begin
      enable_r <= mdss_pkg::EnableW'(1) << idx_r;
      seg_r    <= mdss_pkg::seg_pattern(cur_digit);
      last_r   <= at_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_digit_enable = enable_r;
  assign out_segments_n   = seg_r;
  assign out_last_digit   = last_r;

endmodule

// ----- bench/tb_multiplexed_decimal_seven_segment_scan.sv -----
`timescale 1ns / 1ps

module tb_multiplexed_decimal_seven_segment_scan;

  localparam int unsigned ReadingMax = 1023;
  localparam int unsigned StuckLimit = 4000;
  localparam int unsigned RandItems  = 156;
  localparam int unsigned DrainCycles = 12;

  // One-hot digit selects, units first
  localparam logic [mdss_pkg::EnableW-1:0] EnUnits = 4'b0001;
  localparam logic [mdss_pkg::EnableW-1:0] EnTens  = 4'b0010;
  localparam logic [mdss_pkg::EnableW-1:0] EnHund  = 4'b0100;
  localparam logic [mdss_pkg::EnableW-1:0] EnThou  = 4'b1000;

  typedef struct packed {
    logic [mdss_pkg::EnableW-1:0] enable;
    logic [mdss_pkg::SegW-1:0]    segs;
    logic                         last_digit;
  } digit_result_t;

  typedef struct {
    logic [mdss_pkg::ReadingW-1:0] reading;
    int unsigned                   gap;
    bit                            wait_drain;
  } reading_item_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [mdss_pkg::ReadingW-1:0] in_reading = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [mdss_pkg::EnableW-1:0]  out_digit_enable;
  logic [mdss_pkg::SegW-1:0]     out_segments_n;
  logic                          out_last_digit;

  reading_item_t pending_items[$];
  digit_result_t expected_digits[$];
  int unsigned   results_due = 0;
  int unsigned   results_seen = 0;
  int unsigned   errors = 0;

  int unsigned directed_readings[24] = '{
    0, 1, 9, 10, 11, 99, 100, 101, 999, 1000, 1009, 1010,
    1019, 1023, 512, 341, 682, 5, 58, 123, 456, 789, 90, 900
  };

  multiplexed_decimal_seven_segment_scan u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_reading       (in_reading),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_digit_enable (out_digit_enable),
    .out_segments_n   (out_segments_n),
    .out_last_digit   (out_last_digit)
  );

  // Active-low gfedcba pattern for one decimal digit
  function automatic logic [mdss_pkg::SegW-1:0] unlit_segments(input int unsigned d);
    logic [mdss_pkg::SegW-1:0] lit;
    case (d)
      0: lit = 7'h3F;
      1: lit = 7'h06;
      2: lit = 7'h5B;
      3: lit = 7'h4F;
      4: lit = 7'h66;
      5: lit = 7'h6D;
      6: lit = 7'h7D;
      7: lit = 7'h07;
      8: lit = 7'h7F;
      9: lit = 7'h6F;
      default: lit = 7'h00;
    endcase
    return ~lit;
  endfunction

  function automatic digit_result_t make_digit(input logic [mdss_pkg::EnableW-1:0] en,
                                               input int unsigned d);
    digit_result_t r;
    r.enable     = en;
    r.segs       = unlit_segments(d);
    r.last_digit = 1'b0;
    return r;
  endfunction

  // Split one reading into its shown digits and queue them, units first
  function automatic void queue_digits(input logic [mdss_pkg::ReadingW-1:0] reading);
    digit_result_t digs[$];
    int unsigned   v;
    v = reading;
    if (v > ReadingMax) v = ReadingMax;
    digs.push_back(make_digit(EnUnits, v % 10));
    if (v > 9) digs.push_back(make_digit(EnTens, (v / 10) % 10));
    if (v > 99) digs.push_back(make_digit(EnHund, (v / 100) % 10));
    if (v > 999) digs.push_back(make_digit(EnThou, 1));
    digs[digs.size() - 1].last_digit = 1'b1;
    foreach (digs[i]) expected_digits.push_back(digs[i]);
    results_due += digs.size();
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void add_item(input int unsigned reading, input int unsigned gap,
                                   input bit wait_drain);
    reading_item_t it;
    it.reading    = reading[mdss_pkg::ReadingW-1:0];
    it.gap        = gap;
    it.wait_drain = wait_drain;
    pending_items.push_back(it);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Fill the stimulus queue, release reset, then wait for the drain
  initial begin
    int unsigned burst_left;
    int unsigned gap;
    int unsigned v;
    burst_left = 0;
    foreach (directed_readings[i])
      add_item(directed_readings[i], pick_gap(), i == 12);
    for (int n = 0; n < RandItems; n++) begin
      if (burst_left > 0) begin
        gap = 0;
        burst_left--;
      end else if ($urandom_range(0, 19) == 0) begin
        gap = 0;
        burst_left = $urandom_range(15, 30);
      end else begin
        gap = pick_gap();
      end
      case ($urandom_range(0, 3))
        0: v = $urandom_range(0, 9);
        1: v = $urandom_range(10, 99);
        2: v = $urandom_range(100, 999);
        default: v = $urandom_range(1000, ReadingMax);
      endcase
      add_item(v, gap, $urandom_range(0, 39) == 0);
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || results_seen != results_due);
    repeat (DrainCycles) @(negedge clk);
    if (errors == 0) begin
      $display("tb_multiplexed_decimal_seven_segment_scan: clean");
    end else begin
      $display("tb_multiplexed_decimal_seven_segment_scan: errors");
    end
    $finish;
  end

  // Driver: present queued readings, predict on each transfer
  int unsigned gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) queue_digits(in_reading);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0 &&
                     (!pending_items[0].wait_drain || results_seen == results_due)) begin
          in_valid   <= 1'b1;
          in_reading <= pending_items[0].reading;
          gap_left   = pending_items[0].gap;
          void'(pending_items.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and check each digit transfer
  int unsigned stall_left = 0;
  int unsigned free_left = 0;
  always @(posedge clk) begin
    digit_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_digits.size() == 0) begin
          errors++;
          $display("%0t: unexpected digit: expected none, actual enable %h segs %h last %b",
                   $time, out_digit_enable, out_segments_n, out_last_digit);
        end else begin
          want = expected_digits.pop_front();
          if (out_digit_enable !== want.enable) begin
            errors++;
            $display("%0t: digit_enable expected %h actual %h", $time,
                     want.enable, out_digit_enable);
          end
          if (out_segments_n !== want.segs) begin
            errors++;
            $display("%0t: segments_n expected %h actual %h", $time,
                     want.segs, out_segments_n);
          end
          if (out_last_digit !== want.last_digit) begin
            errors++;
            $display("%0t: last_digit expected %b actual %b", $time,
                     want.last_digit, out_last_digit);
          end
        end
      end
      if (free_left > 0) begin
        free_left--;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 29) == 0) free_left = $urandom_range(20, 60);
        else stall_left = pick_gap();
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long
  int unsigned stuck_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == StuckLimit) begin
      $display("tb_multiplexed_decimal_seven_segment_scan: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/mdss_pkg.sv
hw/rtl/mdss_front.sv
hw/rtl/mdss_queue.sv
hw/rtl/mdss_back.sv
hw/rtl/multiplexed_decimal_seven_segment_scan.sv
bench/tb_multiplexed_decimal_seven_segment_scan.sv
